@@ hdl/blr_pkg.sv @@
// shared types, constants and division helpers for the bilinear resampler
package blr_pkg;

  localparam int OUT_W       = 300;
  localparam int OUT_H       = 300;
  localparam int DIM_MAX     = 256;
  localparam int TABLE_DEPTH = 2048;
  localparam int TIDX_W      = 11;
  localparam int ROW_DEN     = 2 * OUT_H;
  localparam int COL_DEN     = 2 * OUT_W;
  localparam int DIV_SHIFT   = 30;
  localparam int EST_W       = 51;

  localparam logic [20:0] ROW_RECIP = 21'((64'd1 << DIV_SHIFT) / ROW_DEN);
  localparam logic [20:0] COL_RECIP = 21'((64'd1 << DIV_SHIFT) / COL_DEN);

  // interpolated numerator limits for saturation at the top of the table
  localparam longint SAT_LIMIT = longint'(TABLE_DEPTH) * ROW_DEN * COL_DEN;
  localparam longint SAT_VALUE = longint'(TABLE_DEPTH - 1) * ROW_DEN * COL_DEN;

  localparam int QDEPTH  = 8;
  localparam int QPTR_W  = 3;
  localparam int QCNT_W  = 4;

  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_TABLE  = 2'd1;
  localparam logic [1:0] OP_RENDER = 2'd2;

  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_TABLE  = 2'd1;
  localparam logic [1:0] CMD_RENDER = 2'd2;

  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd4;

  typedef struct packed {
    logic [1:0]         op;
    logic [15:0]        address;
    logic signed [15:0] data;
    logic [8:0]         out_col;
    logic [8:0]         out_row;
  } item_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic [8:0] pixel_col;
    logic [8:0] pixel_row;
  } result_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] addr0;
    logic [15:0] addr1;
    logic [15:0] addr2;
    logic [15:0] addr3;
    logic [15:0] data;
    logic [9:0]  fy;
    logic [9:0]  fx;
    logic [8:0]  col;
    logic [8:0]  row;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_push_t;

  typedef struct packed {
    logic [20:0] q;
    logic [9:0]  r;
  } div_res_t;

  function automatic logic [8:0] clamp_dim(input logic [8:0] d);
    logic [8:0] res;
    res = d;
    if (d == 9'd0) res = 9'd1;
    else if (d > 9'(DIM_MAX)) res = 9'(DIM_MAX);
    return res;
  endfunction

  // quotient estimate from the reciprocal is exact or one short
  function automatic div_res_t div_fix(input logic [29:0] n, input logic [20:0] qe,
                                       input logic [9:0] den);
    logic [30:0] rem;
    div_res_t    res;
    rem = 31'(n) - 31'(qe) * 31'(den);
    if (rem >= 31'(den)) begin
      res.q = qe + 21'd1;
      res.r = 10'(rem - 31'(den));
    end else begin
      res.q = qe;
      res.r = 10'(rem);
    end
    return res;
  endfunction

endpackage

@@ hdl/bilinear_resample_with_lut_unit.sv @@
// top level: register port, front end, command queue and back end
// a render reads its four neighbours from the sample store in two phases, two at a time
// over the two read ports; a new render waits until both phases of the last are done and
// for room in the result queue; a load needs a single phase in the back end
// reset clears all control state and sets both dimensions to 256; the stores
// are not cleared
module bilinear_resample_with_lut_unit (
  input  logic             clk,
  input  logic             rst,
  input  blr_pkg::item_t   item,
  input  logic             item_valid,
  output logic             item_ready,
  output blr_pkg::result_t result,
  output logic             result_valid,
  input  logic             result_ready,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import blr_pkg::*;

  logic [8:0]        src_width, src_height;
  cmd_push_t         push;
  cmd_t              head;
  logic              head_valid, pop;
  logic [QCNT_W-1:0] queue_count;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_HEIGHT[2]) ? 32'(src_height) : 32'(src_width);

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= 9'(DIM_MAX);
      src_height <= 9'(DIM_MAX);
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_HEIGHT[2]) src_height <= pwdata[8:0];
      else src_width <= pwdata[8:0];
    end
  end

  blr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .src_width   (src_width),
    .src_height  (src_height),
    .queue_count (queue_count),
    .push        (push)
  );

  blr_cmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .count      (queue_count)
  );

  blr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .head_valid   (head_valid),
    .pop          (pop),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready)
  );

endmodule

@@ hdl/blr_front.sv @@
// front end: accepts words, drops no-ops, computes source positions and addresses
module blr_front (
  input  logic             clk,
  input  logic             rst,
  input  blr_pkg::item_t   item,
  input  logic             item_valid,
  output logic             item_ready,
  input  logic [8:0]       src_width,
  input  logic [8:0]       src_height,
  input  logic [blr_pkg::QCNT_W-1:0] queue_count,
  output blr_pkg::cmd_push_t push
);
  import blr_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] address;
    logic [15:0] data;
    logic [8:0]  col;
    logic [8:0]  row;
  } tag_t;

  logic       v1, v2, v3, v4, v5;
  tag_t       tag1, tag2, tag3, tag4, tag5;
  logic       keep;
  logic [1:0] kind_in;
  logic [8:0] w_eff, h_eff;
  logic [QCNT_W-1:0] occupancy;

  logic [18:0] prod_y, prod_x;
  logic [17:0] ny2, nx2, ny3, nx3;
  logic        posy2, posx2, posy3, posx3;
  logic [EST_W-1:0] ey3, ex3;
  div_res_t    dy, dx;
  logic [8:0]  r0_n, r1_n, c0_n, c1_n;
  logic [8:0]  r0_4, r1_4, c0_4, c1_4, c0_5, c1_5;
  logic [9:0]  fy4, fx4, fy5, fx5;
  logic [15:0] base0, base1;

  assign w_eff = clamp_dim(src_width);
  assign h_eff = clamp_dim(src_height);

  // every word in flight has a queue slot reserved
  assign occupancy  = queue_count + QCNT_W'(v1) + QCNT_W'(v2) + QCNT_W'(v3)
                      + QCNT_W'(v4) + QCNT_W'(v5);
  assign item_ready = occupancy < QCNT_W'(QDEPTH);

  always_comb begin
    keep    = 1'b0;
    kind_in = CMD_SAMPLE;
    unique case (item.op)
      OP_SAMPLE: begin
        keep    = 1'b1;
        kind_in = CMD_SAMPLE;
      end
      OP_TABLE: begin
        keep    = item.address < 16'(TABLE_DEPTH);
        kind_in = CMD_TABLE;
      end
      OP_RENDER: begin
        keep    = (item.out_col < 9'(OUT_W)) && (item.out_row < 9'(OUT_H));
        kind_in = CMD_RENDER;
      end
      default: keep = 1'b0;
    endcase
  end

  always_comb begin
    prod_y = 19'({tag1.row, 1'b1}) * 19'(h_eff);
    prod_x = 19'({tag1.col, 1'b1}) * 19'(w_eff);
  end

  always_comb begin
    dy = div_fix(30'(ny3), ey3[EST_W-1:DIV_SHIFT], 10'(ROW_DEN));
    dx = div_fix(30'(nx3), ex3[EST_W-1:DIV_SHIFT], 10'(COL_DEN));
    r0_n = (9'(dy.q) > h_eff - 9'd1) ? h_eff - 9'd1 : 9'(dy.q);
    c0_n = (9'(dx.q) > w_eff - 9'd1) ? w_eff - 9'd1 : 9'(dx.q);
    if (!posy3) r1_n = 9'd0;
    else if (r0_n + 9'd1 > h_eff - 9'd1) r1_n = h_eff - 9'd1;
    else r1_n = r0_n + 9'd1;
    // right edge wraps round to the first column
    if (!posx3) c1_n = 9'd0;
    else if (c0_n + 9'd1 >= w_eff) c1_n = 9'd0;
    else c1_n = c0_n + 9'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= item_valid && item_ready && keep;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    tag1.kind    <= kind_in;
    tag1.address <= item.address;
    tag1.data    <= item.data;
    tag1.col     <= item.out_col;
    tag1.row     <= item.out_row;
    tag2 <= tag1;
    tag3 <= tag2;
    tag4 <= tag3;
    tag5 <= tag4;

    posy2 <= prod_y > 19'(OUT_H);
    posx2 <= prod_x > 19'(OUT_W);
    ny2   <= (prod_y > 19'(OUT_H)) ? 18'(prod_y - 19'(OUT_H)) : 18'd0;
    nx2   <= (prod_x > 19'(OUT_W)) ? 18'(prod_x - 19'(OUT_W)) : 18'd0;

    posy3 <= posy2;
    posx3 <= posx2;
    ny3   <= ny2;
    nx3   <= nx2;
    ey3   <= EST_W'(ny2) * EST_W'(ROW_RECIP);
    ex3   <= EST_W'(nx2) * EST_W'(COL_RECIP);

    r0_4 <= r0_n;
    r1_4 <= r1_n;
    c0_4 <= c0_n;
    c1_4 <= c1_n;
    fy4  <= dy.r;
    fx4  <= dx.r;

    base0 <= 16'(18'(r0_4) * 18'(w_eff));
    base1 <= 16'(18'(r1_4) * 18'(w_eff));
    c0_5  <= c0_4;
    c1_5  <= c1_4;
    fy5   <= fy4;
    fx5   <= fx4;
  end

  always_comb begin
    push.valid     = v5;
    push.cmd.kind  = tag5.kind;
    push.cmd.data  = tag5.data;
    push.cmd.col   = tag5.col;
    push.cmd.row   = tag5.row;
    push.cmd.fy    = fy5;
    push.cmd.fx    = fx5;
    push.cmd.addr1 = base0 + 16'(c1_5);
    push.cmd.addr2 = base1 + 16'(c0_5);
    push.cmd.addr3 = base1 + 16'(c1_5);
    if (tag5.kind == CMD_RENDER) push.cmd.addr0 = base0 + 16'(c0_5);
    else push.cmd.addr0 = tag5.address;
  end

endmodule

@@ hdl/blr_cmd_queue.sv @@
// command queue between the front end and the back end
module blr_cmd_queue (
  input  logic               clk,
  input  logic               rst,
  input  blr_pkg::cmd_push_t push,
  input  logic               pop,
  output blr_pkg::cmd_t      head,
  output logic               head_valid,
  output logic [blr_pkg::QCNT_W-1:0] count
);
  import blr_pkg::*;

  cmd_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;

  assign head       = slots[rd_ptr];
  assign head_valid = count != '0;

  always_ff @(posedge clk) begin
    if (push.valid) slots[wr_ptr] <= push.cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      count <= count + QCNT_W'(push.valid) - QCNT_W'(pop);
    end
  end

endmodule

@@ hdl/blr_back.sv @@
// back end: sample and table stores, blend arithmetic, result queue
module blr_back (
  input  logic                clk,
  input  logic                rst,
  input  blr_pkg::cmd_t       head,
  input  logic                head_valid,
  output logic                pop,
  output blr_pkg::result_t    result,
  output logic                result_valid,
  input  logic                result_ready
);
  import blr_pkg::*;

  localparam int NSTAGE   = 10;
  localparam int ODEPTH   = 16;
  localparam int OPTR_W   = 4;
  localparam int OCNT_W   = 5;

  typedef struct packed {
    logic              valid;
    logic              is_render;
    logic [8:0]        col;
    logic [8:0]        row;
    logic [9:0]        fy;
    logic [9:0]        fx;
    logic [TIDX_W-1:0] tidx;
    logic [7:0]        tdata;
  } stage_t;

  logic [15:0] smem [65536];
  logic [7:0]  tab  [TABLE_DEPTH];

  stage_t      pipe [1:NSTAGE];
  stage_t      entry;
  logic        phase;
  logic        go_render, issue_render;
  logic        credit_ok;
  logic [15:0] ra0, ra1;
  logic signed [15:0] rd0, rd1, s0a, s0b;
  logic signed [26:0] m00, m10, m01, m11, v0, v1;
  logic signed [37:0] n0, n1, num;
  logic [29:0]        ncl5, ncl6;
  logic [EST_W-1:0]   e1, e2;
  logic [20:0]        q1_7, q1_8;
  div_res_t           d1, d2;
  logic [7:0]         tab_rd;
  logic [OCNT_W-1:0]  inflight, out_count;
  logic [OPTR_W-1:0]  out_wr, out_rd;
  result_t            out_slots [ODEPTH];
  result_t            out_word;
  logic               out_push, out_pop;

  assign credit_ok = (6'(out_count) + 6'(inflight)) < 6'(ODEPTH);
  assign go_render = head_valid && !phase && head.kind == CMD_RENDER && credit_ok;
  assign issue_render = phase;
  // row 0 samples are read in the first phase, row 1 in the second
  assign pop = phase || (head_valid && head.kind != CMD_RENDER);
  assign ra0 = phase ? head.addr2 : head.addr0;
  assign ra1 = phase ? head.addr3 : head.addr1;

  always_comb begin
    entry.valid     = issue_render || (pop && head.kind == CMD_TABLE);
    entry.is_render = issue_render;
    entry.col       = head.col;
    entry.row       = head.row;
    entry.fy        = head.fy;
    entry.fx        = head.fx;
    entry.tidx      = TIDX_W'(head.addr0);
    entry.tdata     = head.data[7:0];
  end

  always_ff @(posedge clk) begin
    if (pop && !phase && head.kind == CMD_SAMPLE) smem[head.addr0] <= head.data;
    rd0 <= smem[ra0];
    rd1 <= smem[ra1];
  end

  always_ff @(posedge clk) begin
    if (pipe[9].valid && !pipe[9].is_render) tab[pipe[9].tidx] <= pipe[9].tdata;
    tab_rd <= tab[pipe[9].tidx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
    end else if (phase) begin
      phase <= 1'b0;
    end else if (go_render) begin
      phase <= 1'b1;
    end
  end

  always_comb begin
    d1 = div_fix(ncl6, e1[EST_W-1:DIV_SHIFT], 10'(ROW_DEN));
    d2 = div_fix(30'(q1_8), e2[EST_W-1:DIV_SHIFT], 10'(COL_DEN));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= NSTAGE; i++) pipe[i].valid <= 1'b0;
    end else begin
      pipe[1].valid <= entry.valid;
      for (int i = 2; i <= NSTAGE; i++) pipe[i].valid <= pipe[i-1].valid;
    end
    if (phase) begin
      s0a <= rd0;
      s0b <= rd1;
    end
    pipe[1].is_render <= entry.is_render;
    pipe[1].col       <= entry.col;
    pipe[1].row       <= entry.row;
    pipe[1].fy        <= entry.fy;
    pipe[1].fx        <= entry.fx;
    pipe[1].tidx      <= entry.tidx;
    pipe[1].tdata     <= entry.tdata;
    for (int i = 2; i <= NSTAGE; i++) begin
      pipe[i].is_render <= pipe[i-1].is_render;
      pipe[i].col       <= pipe[i-1].col;
      pipe[i].row       <= pipe[i-1].row;
      pipe[i].fy        <= pipe[i-1].fy;
      pipe[i].fx        <= pipe[i-1].fx;
      pipe[i].tdata     <= pipe[i-1].tdata;
    end
    for (int i = 2; i <= 8; i++) pipe[i].tidx <= pipe[i-1].tidx;
    pipe[9].tidx      <= pipe[8].is_render ? TIDX_W'(d2.q) : pipe[8].tidx;
    pipe[NSTAGE].tidx <= pipe[NSTAGE-1].tidx;

    // vertical blend of both columns
    m00 <= s0a * $signed({1'b0, 10'(10'(ROW_DEN) - pipe[1].fy)});
    m01 <= s0b * $signed({1'b0, 10'(10'(ROW_DEN) - pipe[1].fy)});
    m10 <= rd0 * $signed({1'b0, pipe[1].fy});
    m11 <= rd1 * $signed({1'b0, pipe[1].fy});
    v0  <= m00 + m10;
    v1  <= m01 + m11;
    // horizontal blend
    n0  <= v0 * $signed({1'b0, 10'(10'(COL_DEN) - pipe[3].fx)});
    n1  <= v1 * $signed({1'b0, pipe[3].fx});
    if (num <= 38'sd0) ncl5 <= 30'd0;
    else if (num >= 38'(SAT_LIMIT)) ncl5 <= 30'(SAT_VALUE);
    else ncl5 <= num[29:0];
    e1   <= EST_W'(ncl5) * EST_W'(ROW_RECIP);
    ncl6 <= ncl5;
    q1_7 <= d1.q;
    e2   <= EST_W'(q1_7) * EST_W'(COL_RECIP);
    q1_8 <= q1_7;
  end

  assign num = n0 + n1;

  assign out_word.pixel     = tab_rd;
  assign out_word.pixel_col = pipe[NSTAGE].col;
  assign out_word.pixel_row = pipe[NSTAGE].row;
  assign out_push = pipe[NSTAGE].valid && pipe[NSTAGE].is_render;
  assign out_pop  = result_valid && result_ready;
  assign result_valid = out_count != '0;
  assign result = out_slots[out_rd];

  always_ff @(posedge clk) begin
    if (out_push) out_slots[out_wr] <= out_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_wr    <= '0;
      out_rd    <= '0;
      out_count <= '0;
      inflight  <= '0;
    end else begin
      if (out_push) out_wr <= out_wr + OPTR_W'(1);
      if (out_pop) out_rd <= out_rd + OPTR_W'(1);
      out_count <= out_count + OCNT_W'(out_push) - OCNT_W'(out_pop);
      inflight  <= inflight + OCNT_W'(issue_render) - OCNT_W'(out_push);
    end
  end

endmodule

@@ hdl/blr_checker.sv @@
// port-level checks for the resampler, bound to the top level
module blr_checker (
  input logic             clk,
  input logic             rst,
  input blr_pkg::result_t result,
  input logic             result_valid,
  input logic             result_ready,
  input logic [31:0]      prdata
);
  import blr_pkg::*;

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result word dropped while stalled");

  a_word_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> $stable(result))
    else $error("result word changed while stalled");

  a_in_grid: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.pixel_col < 9'(OUT_W)) && (result.pixel_row < 9'(OUT_H)))
    else $error("result outside the output grid");

  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  a_read_width: assert property (@(posedge clk) disable iff (rst)
    prdata[31:9] == 23'd0)
    else $error("register read wider than nine bits");

endmodule

bind bilinear_resample_with_lut_unit blr_checker u_checker (.*);

@@ dv/bilinear_resample_with_lut_unit_tb.sv @@
// testbench for the bilinear resampler: directed table, random traffic, scoreboard
module bilinear_resample_with_lut_unit_tb;
  import blr_pkg::*;

  // table entries loaded up front; every random sample blend stays inside them
  localparam int LUT_LOW = 256;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  item_t       item = '0;
  logic        item_valid = 1'b0;
  logic        item_ready;
  result_t     result;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  bilinear_resample_with_lut_unit uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [15:0] img_mem [0:65535];
  logic [7:0]  lut_mem [0:TABLE_DEPTH-1];
  logic [8:0]  cur_w, cur_h;

  result_t     pixel_q[$];
  int          errors = 0;
  int          renders = 0;
  int          loads = 0;
  int          settings = 0;
  longint      cycle = 0;
  bit          hold_rx = 1'b0;
  bit          done = 1'b0;

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > 64'd2000000) begin
      $display("bilinear_resample_with_lut_unit test failed");
      $finish;
    end
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycle);
    errors++;
  endtask

  function automatic logic [8:0] dim_eff(input logic [8:0] d);
    if (d == 9'd0) return 9'd1;
    if (d > 9'(DIM_MAX)) return 9'(DIM_MAX);
    return d;
  endfunction

  // sample values whose blends only reach the loaded low table entries
  function automatic int small_sample();
    return int'($urandom_range(0, 287)) - 32;
  endfunction

  function automatic longint px_at(input longint r, input longint c, input longint w);
    logic [15:0] b;
    b = img_mem[16'((r * w + c) & 65535)];
    return longint'($signed(b));
  endfunction

  // interpolate one output pixel and look it up
  function automatic logic [7:0] resample_pixel(input int oc, input int orw);
    longint w, h, yn, xn, r0, r1, c0, c1, fy, fx, v0, v1, num, s;
    longint dy, dx;
    w = longint'(dim_eff(cur_w)); h = longint'(dim_eff(cur_h));
    dy = 2 * OUT_H; dx = 2 * OUT_W;
    yn = (2 * orw + 1) * h - OUT_H;
    xn = (2 * oc + 1) * w - OUT_W;
    if (yn > 0) begin
      r0 = yn / dy; fy = yn % dy;
      if (r0 > h - 1) r0 = h - 1;
      r1 = r0 + 1;
      if (r1 > h - 1) r1 = h - 1;
    end else begin
      r0 = 0; r1 = 0; fy = 0;
    end
    if (xn > 0) begin
      c0 = xn / dx; fx = xn % dx;
      if (c0 > w - 1) c0 = w - 1;
      c1 = c0 + 1;
      if (c1 >= w) c1 = 0;
    end else begin
      c0 = 0; c1 = 0; fx = 0;
    end
    v0 = px_at(r0, c0, w) * (dy - fy) + px_at(r1, c0, w) * fy;
    v1 = px_at(r0, c1, w) * (dy - fy) + px_at(r1, c1, w) * fy;
    num = v0 * (dx - fx) + v1 * fx;
    s = (num <= 0) ? 0 : num / (dx * dy);
    if (s > TABLE_DEPTH - 1) s = TABLE_DEPTH - 1;
    return lut_mem[s];
  endfunction

  // apply one accepted word to the predictor
  task automatic predict(input item_t it);
    result_t r;
    case (it.op)
      OP_SAMPLE: begin
        img_mem[it.address] = it.data;
        loads++;
      end
      OP_TABLE: begin
        if (it.address < TABLE_DEPTH) lut_mem[it.address] = it.data[7:0];
        loads++;
      end
      OP_RENDER: begin
        if (it.out_col < OUT_W && it.out_row < OUT_H) begin
          r.pixel = resample_pixel(int'(it.out_col), int'(it.out_row));
          r.pixel_col = it.out_col;
          r.pixel_row = it.out_row;
          pixel_q.push_back(r);
          renders++;
        end
      end
      default: ;
    endcase
  endtask

  task automatic send(input item_t it);
    int gap;
    gap = $urandom_range(0, 5);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    predict(it);
  endtask

  task automatic reg_write(input logic [2:0] a, input logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= a; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (a == REG_WIDTH) cur_w = v[8:0];
    else cur_h = v[8:0];
  endtask

  task automatic drain;
    item_valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // receiver with random stalls
  initial begin
    int gap;
    @(negedge rst);
    forever begin
      gap = $urandom_range(0, 5);
      if ($urandom_range(0, 3) == 0) gap = 0;
      repeat (gap) @(posedge clk);
      while (hold_rx) @(posedge clk);
      result_ready <= 1'b1;
      do @(posedge clk); while (!result_valid);
      result_ready <= 1'b0;
    end
  end

  // scoreboard
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (pixel_q.size() == 0) begin
        report("unexpected pixel", 32'(result.pixel), 32'd0);
      end else begin
        result_t e;
        e = pixel_q.pop_front();
        if (result.pixel !== e.pixel) report("pixel", 32'(result.pixel), 32'(e.pixel));
        if (result.pixel_col !== e.pixel_col)
          report("pixel_col", 32'(result.pixel_col), 32'(e.pixel_col));
        if (result.pixel_row !== e.pixel_row)
          report("pixel_row", 32'(result.pixel_row), 32'(e.pixel_row));
      end
    end
  end

  function automatic item_t mk(input logic [1:0] op, input int a, input int d,
                               input int c, input int r);
    item_t it;
    it.op = op; it.address = 16'(a); it.data = 16'(d);
    it.out_col = 9'(c); it.out_row = 9'(r);
    return it;
  endfunction

  // load a whole image of w x h with random content
  task automatic fill_image(input int w, input int h, input bit extreme);
    int v;
    for (int i = 0; i < w * h; i++) begin
      v = extreme ? (($urandom_range(0, 1) != 0) ? LUT_LOW - 1 : -32768) : small_sample();
      send(mk(OP_SAMPLE, i, v, $urandom, $urandom));
    end
  endtask

  task automatic fill_table(input int n);
    for (int i = 0; i < n; i++)
      send(mk(OP_TABLE, $urandom_range(0, TABLE_DEPTH - 1), $urandom, $urandom, $urandom));
  endtask

  task automatic rand_render;
    int oc, orw;
    oc = $urandom_range(0, OUT_W - 1);
    orw = $urandom_range(0, OUT_H - 1);
    send(mk(OP_RENDER, $urandom, $urandom, oc, orw));
  endtask

  typedef struct {
    item_t      it;
    bit         has_want;
    logic [7:0] want;
  } row_t;

  initial begin
    row_t   dir[$];
    row_t   rw;
    int     w, h, n;
    logic [31:0] rd;
    for (int i = 0; i < TABLE_DEPTH; i++) lut_mem[i] = '0;
    cur_w = 9'd256; cur_h = 9'd256;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: tiny 2x2 image, low table entries and the top entry written
    reg_write(REG_WIDTH, 2);
    reg_write(REG_HEIGHT, 2);
    for (int i = 0; i < LUT_LOW; i++) send(mk(OP_TABLE, i, i ^ 8'h5a, 0, 0));
    send(mk(OP_TABLE, TABLE_DEPTH - 1, (TABLE_DEPTH - 1) ^ 8'h5a, 0, 0));
    dir.push_back('{mk(OP_SAMPLE, 0, -32768, 0, 0), 0, 0});
    dir.push_back('{mk(OP_SAMPLE, 1, 32767, 511, 511), 0, 0});
    dir.push_back('{mk(OP_SAMPLE, 2, 0, 0, 0), 0, 0});
    dir.push_back('{mk(OP_SAMPLE, 3, 400, 0, 0), 0, 0});
    // non-positive position: top-left corner uses sample 0 alone, floors to 0
    dir.push_back('{mk(OP_RENDER, 0, 0, 0, 0), 1, 8'h5a});
    dir.push_back('{mk(OP_RENDER, 0, 0, 299, 299), 0, 0});
    dir.push_back('{mk(OP_RENDER, 0, 0, 299, 0), 0, 0});
    dir.push_back('{mk(OP_RENDER, 0, 0, 0, 299), 0, 0});
    dir.push_back('{mk(OP_RENDER, 0, 0, 150, 150), 0, 0});
    // out of grid, unused op, table load out of range: no result
    dir.push_back('{mk(OP_RENDER, 0, 0, 300, 0), 0, 0});
    dir.push_back('{mk(OP_RENDER, 0, 0, 0, 300), 0, 0});
    dir.push_back('{mk(OP_RENDER, 0, 0, 511, 511), 0, 0});
    dir.push_back('{mk(2'd3, 65535, -1, 511, 511), 0, 0});
    dir.push_back('{mk(OP_TABLE, 65535, -1, 0, 0), 0, 0});
    dir.push_back('{mk(OP_TABLE, TABLE_DEPTH, 255, 0, 0), 0, 0});
    // saturation to the top entry
    dir.push_back('{mk(OP_SAMPLE, 0, 32767, 0, 0), 0, 0});
    dir.push_back('{mk(OP_RENDER, 0, 0, 0, 0), 1, 8'(11'h7ff ^ 8'h5a)});
    dir.push_back('{mk(OP_SAMPLE, 65535, 32767, 0, 0), 0, 0});
    foreach (dir[i]) begin
      rw = dir[i];
      if (rw.has_want) begin
        logic [7:0] p;
        p = resample_pixel(int'(rw.it.out_col), int'(rw.it.out_row));
        if (p !== rw.want) report("directed predictor", 32'(p), 32'(rw.want));
      end
      send(rw.it);
    end
    drain();
    settings++;

    // random phases over several sizes, extremes included
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin w = 1; h = 1; end
        1: begin w = 511; h = 1; end
        2: begin w = 1; h = 256; end
        3: begin w = 0; h = 0; end
        4: begin w = 3; h = 3; end
        default: begin w = $urandom_range(1, 8); h = $urandom_range(1, 8); end
      endcase
      reg_write(REG_WIDTH, {$urandom} & 32'hffff_fe00 | 32'(w));
      reg_write(REG_HEIGHT, 32'(h));
      @(posedge clk);
      psel <= 1'b1; paddr <= REG_WIDTH; penable <= 1'b0; pwrite <= 1'b0;
      @(posedge clk); penable <= 1'b1; @(posedge clk);
      rd = prdata;
      psel <= 1'b0; penable <= 1'b0;
      if (rd[8:0] !== 9'(w)) report("width readback", 32'(rd[8:0]), 32'(w));
      settings++;
      w = int'(dim_eff(9'(w))); h = int'(dim_eff(9'(h)));
      fill_image(w, h, ph == 6);
      fill_table(3);
      if (ph == 7) begin
        // long receiver hold-off while renders keep coming
        hold_rx = 1'b1;
        fork
          begin repeat (300) @(posedge clk); hold_rx = 1'b0; end
          for (int k = 0; k < 40; k++) rand_render();
        join
      end
      n = 20;
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 9) == 0)
          send(mk(2'($urandom), $urandom, small_sample(), $urandom, $urandom));
        else if ($urandom_range(0, 9) == 0)
          send(mk(OP_SAMPLE, $urandom_range(0, w * h - 1), small_sample(), $urandom, $urandom));
        else rand_render();
      end
      drain();
    end

    $display("covered %0d loads, %0d checked pixels over %0d size settings",
             loads, renders, settings);
    if (errors == 0) begin
      $display("bilinear_resample_with_lut_unit test passed");
    end else begin
      $display("bilinear_resample_with_lut_unit test failed");
    end
    $finish;
  end

endmodule

@@ bilinear_resample_with_lut_unit.f @@
hdl/blr_pkg.sv
hdl/blr_front.sv
hdl/blr_cmd_queue.sv
hdl/blr_back.sv
hdl/bilinear_resample_with_lut_unit.sv
hdl/blr_checker.sv
dv/bilinear_resample_with_lut_unit_tb.sv
